// ----- rtl/char_lcd_nibble_writer_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the character LCD nibble writer
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_WRITER_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LCDNW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define LCDNW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/lcdnw_pkg.sv -----
// ----------------------------------------------------------------------------
// lcdnw_pkg
// Types, register map, reset values and the init command table.
// ----------------------------------------------------------------------------
package lcdnw_pkg;

  // Configuration port geometry
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int REG_IDX_W = 3;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_PULSE        = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SETTLE_SHORT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SETTLE_CLEAR = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_POWER_ON     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_INIT_GAP1    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_INIT_GAP2    = 3'd5;

  // Reset values
  localparam logic [9:0]  RST_PULSE        = 10'd50;
  localparam logic [9:0]  RST_SETTLE_SHORT = 10'd50;
  localparam logic [15:0] RST_SETTLE_CLEAR = 16'd2000;
  localparam logic [16:0] RST_POWER_ON     = 17'd50000;
  localparam logic [15:0] RST_INIT_GAP1    = 16'd5000;
  localparam logic [15:0] RST_INIT_GAP2    = 16'd200;

  // Request modes
  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_CMD  = 2'd1;
  localparam logic [1:0] MODE_DATA = 2'd2;
  localparam logic [1:0] MODE_INIT = 2'd3;

  // Commands below this value need the long settle wait
  localparam logic [7:0] CMD_SLOW_LIMIT = 8'h04;

  // Index of the last init command
  localparam logic [3:0] INIT_LAST = 4'd8;

  typedef struct packed {
    logic [9:0]  pulse_us;
    logic [9:0]  settle_short_us;
    logic [15:0] settle_clear_us;
    logic [16:0] power_on_us;
    logic [15:0] init_gap1_us;
    logic [15:0] init_gap2_us;
  } cfg_t;

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_POWER  = 7'b0000010,
    PH_HI_EN  = 7'b0000100,
    PH_HI_LOW = 7'b0001000,
    PH_LO_EN  = 7'b0010000,
    PH_LO_LOW = 7'b0100000,
    PH_SETTLE = 7'b1000000
  } phase_t;

  // Power-on command sequence
  function automatic logic [7:0] init_byte(input logic [3:0] step);
    logic [7:0] b;
    case (step)
      4'd0: b = 8'h30;
      4'd1: b = 8'h30;
      4'd2: b = 8'h30;
      4'd3: b = 8'h20;
      4'd4: b = 8'h28;
      4'd5: b = 8'h08;
      4'd6: b = 8'h01;
      4'd7: b = 8'h06;
      default: b = 8'h0F;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/lcdnw_regs.sv -----
// ----------------------------------------------------------------------------
// lcdnw_regs
// APB-style timing register file for the LCD writer.
// ----------------------------------------------------------------------------
module lcdnw_regs import lcdnw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_us        <= RST_PULSE;
      cfg.settle_short_us <= RST_SETTLE_SHORT;
      cfg.settle_clear_us <= RST_SETTLE_CLEAR;
      cfg.power_on_us     <= RST_POWER_ON;
      cfg.init_gap1_us    <= RST_INIT_GAP1;
      cfg.init_gap2_us    <= RST_INIT_GAP2;
    end else if (wr_en) begin
      case (idx)
        REG_PULSE:        cfg.pulse_us        <= pwdata[9:0];
        REG_SETTLE_SHORT: cfg.settle_short_us <= pwdata[9:0];
        REG_SETTLE_CLEAR: cfg.settle_clear_us <= pwdata[15:0];
        REG_POWER_ON:     cfg.power_on_us     <= pwdata[16:0];
        REG_INIT_GAP1:    cfg.init_gap1_us    <= pwdata[15:0];
        REG_INIT_GAP2:    cfg.init_gap2_us    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (idx)
      REG_PULSE:        prdata = {22'd0, cfg.pulse_us};
      REG_SETTLE_SHORT: prdata = {22'd0, cfg.settle_short_us};
      REG_SETTLE_CLEAR: prdata = {16'd0, cfg.settle_clear_us};
      REG_POWER_ON:     prdata = {15'd0, cfg.power_on_us};
      REG_INIT_GAP1:    prdata = {16'd0, cfg.init_gap1_us};
      REG_INIT_GAP2:    prdata = {16'd0, cfg.init_gap2_us};
      default:          prdata = '0;
    endcase
  end

endmodule

// ----- rtl/lcdnw_seq.sv -----
// ----------------------------------------------------------------------------
// lcdnw_seq
// Per-tick phase sequencer with a registered pin/status output stage.
// ----------------------------------------------------------------------------
module lcdnw_seq import lcdnw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] mode,
  input  logic [7:0] byte_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       rs_level,
  output logic       rw_level,
  output logic       en_level,
  output logic [3:0] bus_nibble,
  output logic       busy_res,
  output logic       accepted
);

  // Sequencer state
  phase_t      phase, phase_next;
  logic [16:0] wait_counter, wait_counter_next;
  logic [7:0]  held_byte, held_byte_next;
  logic        held_is_data, held_is_data_next;
  logic [3:0]  init_step, init_step_next;
  logic        in_init, in_init_next;

  // Intermediate values after the timer advance
  phase_t      ph_a;
  logic [16:0] wc_a;
  logic [7:0]  hb_a;
  logic        hd_a;
  logic [3:0]  step_a;
  logic        ii_a;

  logic        take;
  logic        taken;
  logic [16:0] pulse1;
  logic [16:0] power1;
  logic [16:0] settle_base;
  logic [16:0] settle_gap;
  logic [16:0] settle_sum;
  logic [16:0] settle1;
  logic [3:0]  step_inc;

  // Hold the input while a finished result is stalled
  assign in_stall = out_valid & out_stall;
  assign take     = in_valid & ~in_stall;

  // Phase lengths, a zero register counts as one tick
  assign pulse1 = (cfg.pulse_us == '0) ? 17'd1 : {7'd0, cfg.pulse_us};
  assign power1 = (cfg.power_on_us == '0) ? 17'd1 : cfg.power_on_us;

  assign settle_base = (!held_is_data && held_byte < CMD_SLOW_LIMIT) ?
                       {1'b0, cfg.settle_clear_us} : {7'd0, cfg.settle_short_us};
  assign settle_gap  = (in_init && init_step == 4'd0) ? {1'b0, cfg.init_gap1_us} :
                       (in_init && init_step == 4'd1) ? {1'b0, cfg.init_gap2_us} : '0;
  assign settle_sum  = settle_base + settle_gap;
  assign settle1     = (settle_sum == '0) ? 17'd1 : settle_sum;
  assign step_inc    = init_step + 4'd1;

  // Advance the timer and move to the next phase on expiry
  always_comb begin
    ph_a   = phase;
    wc_a   = wait_counter;
    hb_a   = held_byte;
    hd_a   = held_is_data;
    step_a = init_step;
    ii_a   = in_init;
    if (phase != PH_IDLE) begin
      if (wait_counter <= 17'd1) begin
        case (phase)
          PH_POWER: begin
            step_a = 4'd0;
            hb_a   = init_byte(4'd0);
            hd_a   = 1'b0;
            ph_a   = PH_HI_EN;
            wc_a   = pulse1;
          end
          PH_HI_EN: begin
            ph_a = PH_HI_LOW;
            wc_a = pulse1;
          end
          PH_HI_LOW: begin
            ph_a = PH_LO_EN;
            wc_a = pulse1;
          end
          PH_LO_EN: begin
            ph_a = PH_LO_LOW;
            wc_a = pulse1;
          end
          PH_LO_LOW: begin
            ph_a = PH_SETTLE;
            wc_a = settle1;
          end
          PH_SETTLE: begin
            if (in_init && init_step < INIT_LAST) begin
              step_a = step_inc;
              hb_a   = init_byte(step_inc);
              hd_a   = 1'b0;
              ph_a   = PH_HI_EN;
              wc_a   = pulse1;
            end else begin
              ii_a = 1'b0;
              ph_a = PH_IDLE;
              wc_a = '0;
            end
          end
          default: begin
            ph_a = PH_IDLE;
            wc_a = '0;
          end
        endcase
      end else begin
        wc_a = wait_counter - 17'd1;
      end
    end
  end

  // Take a request when the sequencer is idle after the advance
  always_comb begin
    phase_next        = ph_a;
    wait_counter_next = wc_a;
    held_byte_next    = hb_a;
    held_is_data_next = hd_a;
    init_step_next    = step_a;
    in_init_next      = ii_a;
    taken             = 1'b0;
    if (ph_a == PH_IDLE) begin
      case (mode)
        MODE_CMD, MODE_DATA: begin
          held_byte_next    = byte_value;
          held_is_data_next = (mode == MODE_DATA);
          phase_next        = PH_HI_EN;
          wait_counter_next = pulse1;
          taken             = 1'b1;
        end
        MODE_INIT: begin
          in_init_next      = 1'b1;
          init_step_next    = 4'd0;
          held_byte_next    = '0;
          held_is_data_next = 1'b0;
          phase_next        = PH_POWER;
          wait_counter_next = power1;
          taken             = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Update state once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      wait_counter <= '0;
      held_byte    <= '0;
      held_is_data <= 1'b0;
      init_step    <= '0;
      in_init      <= 1'b0;
    end else if (take) begin
      phase        <= phase_next;
      wait_counter <= wait_counter_next;
      held_byte    <= held_byte_next;
      held_is_data <= held_is_data_next;
      init_step    <= init_step_next;
      in_init      <= in_init_next;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload, loaded with each transaction
  always_ff @(posedge clk) begin
    if (take) begin
      rs_level   <= held_is_data_next;
      rw_level   <= 1'b0;
      en_level   <= (phase_next == PH_HI_EN) || (phase_next == PH_LO_EN);
      bus_nibble <= ((phase_next == PH_HI_EN) || (phase_next == PH_HI_LOW)) ?
                    held_byte_next[7:4] : held_byte_next[3:0];
      busy_res   <= (phase_next != PH_IDLE);
      accepted   <= taken;
    end
  end

endmodule

// ----- rtl/char_lcd_nibble_writer.sv -----
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer
// Character LCD writer for a 4-bit bus: one microsecond tick per transaction.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                | Payload
//  ---------+--------------------------+-----------------------------------
//  in       | in_valid / in_stall      | mode, byte_value
//  out      | out_valid / out_stall    | rs_level, rw_level, en_level,
//           |                          | bus_nibble, busy_res, accepted
//  config   | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
//  One tick enters per clock unless in_stall holds it; its result is
//  registered in the next cycle. Timer and phase logic are combinational.
//  in_stall rises only while a result sits in the output register and
//  out_stall holds it; a tick can enter in the same cycle a result leaves.
//  rst is synchronous: it idles the sequencer and restores the timing
//  registers to their default values.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer import lcdnw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        mode,
  input  logic [7:0]        byte_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              rs_level,
  output logic              rw_level,
  output logic              en_level,
  output logic [3:0]        bus_nibble,
  output logic              busy_res,
  output logic              accepted,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;

  // Timing registers
  lcdnw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Phase sequencer and output stage
  lcdnw_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .byte_value (byte_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .rs_level   (rs_level),
    .rw_level   (rw_level),
    .en_level   (en_level),
    .bus_nibble (bus_nibble),
    .busy_res   (busy_res),
    .accepted   (accepted)
  );

endmodule

// ----- rtl/lcdnw_checker.sv -----
// ----------------------------------------------------------------------------
// lcdnw_checker
// Port-level checks for the LCD writer, bound to the top level.
// ----------------------------------------------------------------------------
`include "char_lcd_nibble_writer_macros.svh"

module lcdnw_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       rw_level,
  input logic       en_level,
  input logic [3:0] bus_nibble,
  input logic       busy_res,
  input logic       accepted
);

  // Every accepted tick yields a result in the next cycle
  `LCDNW_ASSERT_NEXT(a_result_follows, in_valid && !in_stall, out_valid, "tick without result")

  // An enable pulse or a taken request implies the block is busy
  `LCDNW_ASSERT_NOW(a_en_busy, out_valid && (en_level || accepted), busy_res, "enable while idle")

  // Write-only bus
  `LCDNW_ASSERT_NOW(a_rw_low, out_valid, !rw_level, "rw driven high")

  // A stalled result stays valid and keeps its bus nibble
  `LCDNW_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(bus_nibble), "result dropped")

endmodule

bind char_lcd_nibble_writer lcdnw_checker u_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .rw_level   (rw_level),
  .en_level   (en_level),
  .bus_nibble (bus_nibble),
  .busy_res   (busy_res),
  .accepted   (accepted)
);

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer regression
// Streams microsecond ticks, with command, data and power-up requests mixed
// in, through the block. Random sender gaps and receiver stalls are applied.
// A cycle-free shadow of the LCD sequencer predicts the pin levels, busy flag
// and accept flag of every tick. Each output transaction is checked field by
// field against the oldest prediction. The timing registers are written and
// read back over the APB port with minimum, zero, random and maximum values.
// ----------------------------------------------------------------------------
module testbench;
  import lcdnw_pkg::*;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] val;
  } lcd_req_t;

  typedef struct packed {
    logic       rs;
    logic       rw;
    logic       en;
    logic [3:0] nibble;
    logic       busy;
    logic       taken;
  } lcd_pins_t;

  // Power-up command bytes, entry 0 goes out first
  localparam logic [8:0][7:0] POWER_UP_BYTES = {8'h0F, 8'h06, 8'h01, 8'h08, 8'h28,
                                                8'h20, 8'h30, 8'h30, 8'h30};
  localparam int LONG_HOLD = 400;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          mode = MODE_TICK;
  logic [7:0]          byte_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                rs_level;
  logic                rw_level;
  logic                en_level;
  logic [3:0]          bus_nibble;
  logic                busy_res;
  logic                accepted;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Shadow of the sequencer and its timing registers
  cfg_t        cfg;
  phase_t      seq_phase;
  logic [16:0] seq_count;
  logic [7:0]  seq_byte;
  logic        seq_is_data;
  logic [3:0]  seq_step;
  logic        seq_in_init;

  lcd_req_t  tick_q[$];
  lcd_pins_t pins_due_q[$];
  lcd_req_t  req;
  lcd_pins_t want;

  int          fail_cnt = 0;
  int          busy_items = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          hold_requests = 0;
  int          holds_done = 0;
  int          hold_left = 0;
  int unsigned stall_style = 0;
  int unsigned style_left = 0;

  char_lcd_nibble_writer u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .byte_value (byte_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .rs_level   (rs_level),
    .rw_level   (rw_level),
    .en_level   (en_level),
    .bus_nibble (bus_nibble),
    .busy_res   (busy_res),
    .accepted   (accepted),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // Failure bookkeeping
  // ------------------------------------------------------------------
  task automatic note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%s", msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v)
      note_failure($sformatf("%s mismatch: expected %0h, got %0h", name, want_v, got_v));
  endtask

  // ------------------------------------------------------------------
  // Sequencer shadow
  // ------------------------------------------------------------------
  function automatic logic [16:0] floor_one(input logic [16:0] d);
    return (d == 17'd0) ? 17'd1 : d;
  endfunction

  task automatic reset_lcd_state();
    cfg.pulse_us        = RST_PULSE;
    cfg.settle_short_us = RST_SETTLE_SHORT;
    cfg.settle_clear_us = RST_SETTLE_CLEAR;
    cfg.power_on_us     = RST_POWER_ON;
    cfg.init_gap1_us    = RST_INIT_GAP1;
    cfg.init_gap2_us    = RST_INIT_GAP2;
    seq_phase   = PH_IDLE;
    seq_count   = '0;
    seq_byte    = '0;
    seq_is_data = 1'b0;
    seq_step    = '0;
    seq_in_init = 1'b0;
  endtask

  task automatic load_byte(input logic [7:0] b, input logic is_data);
    seq_byte    = b;
    seq_is_data = is_data;
    seq_phase   = PH_HI_EN;
    seq_count   = floor_one({7'd0, cfg.pulse_us});
  endtask

  // Clear and home commands take the long wait; the first two 8-bit
  // function sets of power-up carry an extra gap
  function automatic logic [16:0] settle_ticks();
    logic [16:0] t;
    if (!seq_is_data && seq_byte < CMD_SLOW_LIMIT) t = {1'b0, cfg.settle_clear_us};
    else t = {7'd0, cfg.settle_short_us};
    if (seq_in_init && seq_step == 4'd0) t = t + {1'b0, cfg.init_gap1_us};
    else if (seq_in_init && seq_step == 4'd1) t = t + {1'b0, cfg.init_gap2_us};
    return floor_one(t);
  endfunction

  task automatic next_seq_phase();
    case (seq_phase)
      PH_POWER: begin
        seq_step = 4'd0;
        load_byte(POWER_UP_BYTES[0], 1'b0);
      end
      PH_HI_EN: begin
        seq_phase = PH_HI_LOW;
        seq_count = floor_one({7'd0, cfg.pulse_us});
      end
      PH_HI_LOW: begin
        seq_phase = PH_LO_EN;
        seq_count = floor_one({7'd0, cfg.pulse_us});
      end
      PH_LO_EN: begin
        seq_phase = PH_LO_LOW;
        seq_count = floor_one({7'd0, cfg.pulse_us});
      end
      PH_LO_LOW: begin
        seq_phase = PH_SETTLE;
        seq_count = settle_ticks();
      end
      PH_SETTLE: begin
        if (seq_in_init && seq_step < INIT_LAST) begin
          seq_step = seq_step + 4'd1;
          load_byte(POWER_UP_BYTES[seq_step], 1'b0);
        end else begin
          seq_in_init = 1'b0;
          seq_phase   = PH_IDLE;
          seq_count   = '0;
        end
      end
      default: begin
        seq_phase = PH_IDLE;
        seq_count = '0;
      end
    endcase
  endtask

  // Advance one microsecond and queue the pin levels it should produce
  task automatic lcd_tick_pins(input logic [1:0] req_mode, input logic [7:0] req_byte);
    lcd_pins_t p;
    logic      was_busy;
    was_busy = (seq_phase != PH_IDLE);
    p.taken = 1'b0;
    if (seq_phase != PH_IDLE) begin
      if (seq_count <= 17'd1) next_seq_phase();
      else seq_count = seq_count - 17'd1;
    end
    if (seq_phase == PH_IDLE) begin
      case (req_mode)
        MODE_CMD: begin
          load_byte(req_byte, 1'b0);
          p.taken = 1'b1;
        end
        MODE_DATA: begin
          load_byte(req_byte, 1'b1);
          p.taken = 1'b1;
        end
        MODE_INIT: begin
          seq_in_init = 1'b1;
          seq_step    = 4'd0;
          seq_byte    = 8'd0;
          seq_is_data = 1'b0;
          seq_phase   = PH_POWER;
          seq_count   = floor_one(cfg.power_on_us);
          p.taken     = 1'b1;
        end
        default: ;
      endcase
    end
    p.rs     = seq_is_data;
    p.rw     = 1'b0;
    p.en     = (seq_phase == PH_HI_EN || seq_phase == PH_LO_EN);
    p.nibble = (seq_phase == PH_HI_EN || seq_phase == PH_HI_LOW) ? seq_byte[7:4]
                                                                 : seq_byte[3:0];
    p.busy   = (seq_phase != PH_IDLE);
    if (was_busy || p.taken) busy_items++;
    pins_due_q.push_back(p);
  endtask

  // ------------------------------------------------------------------
  // Driver: score accepted transactions, then present the next tick
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      mode       <= MODE_TICK;
      byte_value <= '0;
      burst_left = 0;
      gap_left   = 0;
      busy_items = 0;
      reset_lcd_state();
    end else begin
      if (in_valid && !in_stall) lcd_tick_pins(mode, byte_value);
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          req = tick_q.pop_front();
          in_valid   <= 1'b1;
          mode       <= req.mode;
          byte_value <= req.val;
          // close the burst and pick the gap that follows it
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left = burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Receiver stall: long hold on request, otherwise a changing pattern
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left   = 0;
      holds_done  = 0;
      style_left  = 0;
      stall_style = 0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (holds_done != hold_requests) begin
      holds_done = holds_done + 1;
      hold_left  = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 3);
        style_left  = $urandom_range(50, 300);
      end else begin
        style_left = style_left - 1;
      end
      case (stall_style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 7) == 0);
        2: out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= (style_left % 4 == 0);
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Monitor: compare each output transaction with the oldest prediction
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pins_due_q.size() == 0) begin
        note_failure("output transaction with no prediction pending");
      end else begin
        want = pins_due_q.pop_front();
        check_field("rs_level", 32'(want.rs), 32'(rs_level));
        check_field("rw_level", 32'(want.rw), 32'(rw_level));
        check_field("en_level", 32'(want.en), 32'(en_level));
        check_field("bus_nibble", 32'(want.nibble), 32'(bus_nibble));
        check_field("busy_res", 32'(want.busy), 32'(busy_res));
        check_field("accepted", 32'(want.taken), 32'(accepted));
      end
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  task automatic access_timing_reg(input logic [REG_IDX_W-1:0] idx, input logic is_write,
                                   input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (!is_write) check_field($sformatf("prdata[%0d]", idx), value, prdata);
    @(negedge clk);
  endtask

  task automatic write_timing_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    access_timing_reg(idx, 1'b1, value);
    case (idx)
      REG_PULSE:        cfg.pulse_us        = value[9:0];
      REG_SETTLE_SHORT: cfg.settle_short_us = value[9:0];
      REG_SETTLE_CLEAR: cfg.settle_clear_us = value[15:0];
      REG_POWER_ON:     cfg.power_on_us     = value[16:0];
      REG_INIT_GAP1:    cfg.init_gap1_us    = value[15:0];
      REG_INIT_GAP2:    cfg.init_gap2_us    = value[15:0];
      default: ;
    endcase
    // read back what was just written
    access_timing_reg(idx, 1'b0, value);
  endtask

  task automatic load_timing(input int pulse, input int s_short, input int s_clear,
                             input int power, input int gap1, input int gap2);
    write_timing_reg(REG_PULSE, pulse);
    write_timing_reg(REG_SETTLE_SHORT, s_short);
    write_timing_reg(REG_SETTLE_CLEAR, s_clear);
    write_timing_reg(REG_POWER_ON, power);
    write_timing_reg(REG_INIT_GAP1, gap1);
    write_timing_reg(REG_INIT_GAP2, gap2);
  endtask

  task automatic queue_req(input logic [1:0] m, input logic [7:0] v);
    lcd_req_t r;
    r.mode = m;
    r.val  = v;
    tick_q.push_back(r);
  endtask

  // Wait until every tick is taken and every result has come back
  task automatic wait_drained();
    @(negedge clk);
    while (tick_q.size() != 0 || in_valid || pins_due_q.size() != 0) @(negedge clk);
  endtask

  // Feed plain ticks until the sequencer is back to idle
  task automatic run_until_idle();
    wait_drained();
    while (seq_phase != PH_IDLE) begin
      repeat (32) queue_req(MODE_TICK, 8'($urandom_range(0, 255)));
      wait_drained();
    end
  endtask

  function automatic lcd_req_t random_req();
    lcd_req_t    r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) r.mode = MODE_TICK;
    else if (pick < 75) r.mode = MODE_CMD;
    else if (pick < 93) r.mode = MODE_DATA;
    else r.mode = MODE_INIT;
    // lean on the clear/home boundary and the all-ones byte
    case ($urandom_range(0, 7))
      0: r.val = 8'($urandom_range(0, 5));
      1: r.val = 8'hFF;
      default: r.val = 8'($urandom_range(0, 255));
    endcase
    return r;
  endfunction

  // ------------------------------------------------------------------
  // Test sequence
  // ------------------------------------------------------------------
  initial begin
    int       phase_start;
    int       ph;
    lcd_req_t r_item;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Check the timing registers come out of reset with their defaults
    access_timing_reg(REG_PULSE, 1'b0, 32'(RST_PULSE));
    access_timing_reg(REG_SETTLE_SHORT, 1'b0, 32'(RST_SETTLE_SHORT));
    access_timing_reg(REG_SETTLE_CLEAR, 1'b0, 32'(RST_SETTLE_CLEAR));
    access_timing_reg(REG_POWER_ON, 1'b0, 32'(RST_POWER_ON));
    access_timing_reg(REG_INIT_GAP1, 1'b0, 32'(RST_INIT_GAP1));
    access_timing_reg(REG_INIT_GAP2, 1'b0, 32'(RST_INIT_GAP2));

    // One data byte with the default pulse and settle times
    queue_req(MODE_DATA, 8'h48);
    run_until_idle();

    // Short timing for the directed cases
    load_timing(2, 3, 9, 20, 7, 5);

    // Directed: idle tick, clear command, and requests while busy
    queue_req(MODE_TICK, 8'h00);
    queue_req(MODE_CMD, 8'h01);
    queue_req(MODE_CMD, 8'h30);
    queue_req(MODE_INIT, 8'h00);
    queue_req(MODE_DATA, 8'h55);
    run_until_idle();
    // data of all ones, then a busy data request
    queue_req(MODE_DATA, 8'hFF);
    queue_req(MODE_DATA, 8'h00);
    run_until_idle();
    // settle boundary: below the limit, at the limit, data below the limit
    queue_req(MODE_CMD, 8'h03);
    run_until_idle();
    queue_req(MODE_CMD, 8'h04);
    run_until_idle();
    queue_req(MODE_DATA, 8'h02);
    run_until_idle();
    // power-up clears the pins left by an all-ones byte
    queue_req(MODE_DATA, 8'hFF);
    run_until_idle();
    queue_req(MODE_INIT, 8'hAA);
    queue_req(MODE_TICK, 8'h00);
    queue_req(MODE_INIT, 8'h00);
    queue_req(MODE_CMD, 8'h01);
    run_until_idle();

    // Long pulse; shorten the pulse mid-byte
    load_timing(40, 30, 60, 1, 1, 1);
    queue_req(MODE_CMD, 8'h00);
    repeat (8) queue_req(MODE_TICK, 8'h00);
    wait_drained();
    write_timing_reg(REG_PULSE, 1);
    run_until_idle();
    queue_req(MODE_DATA, 8'hA5);
    run_until_idle();

    // Power-up with a longer wait and longer init gaps
    load_timing(1, 1, 1, 60, 40, 30);
    queue_req(MODE_INIT, 8'h00);
    run_until_idle();

    // Largest register values, written and read back
    load_timing(1023, 1023, 65535, 131071, 65535, 65535);

    // Random phases: zero values, ones, then small random timing
    for (ph = 0; ph < 6; ph++) begin
      if (ph == 0) load_timing(0, 0, 0, 0, 0, 0);
      else if (ph == 1) load_timing(1, 1, 1, 1, 1, 1);
      else load_timing($urandom_range(1, 4), $urandom_range(0, 6), $urandom_range(0, 24),
                       $urandom_range(0, 40), $urandom_range(0, 12), $urandom_range(0, 12));
      phase_start = busy_items;
      while (busy_items - phase_start < 100) begin
        repeat (64) begin
          r_item = random_req();
          queue_req(r_item.mode, r_item.val);
        end
        // hold the output off so the block backs up into its input
        if (ph == 2 || ph == 4) hold_requests++;
        wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (pins_due_q.size() != 0) note_failure("predictions left without a result");
    if (fail_cnt == 0) begin
      $display("char_lcd_nibble_writer regression: pass");
    end else begin
      $display("char_lcd_nibble_writer regression: fail");
    end
    $finish;
  end

  // Hard stop for a hung run
  initial begin
    #1_000_000;
    $display("char_lcd_nibble_writer regression: fail");
    $finish;
  end

endmodule
